// ===== sv/assert_macros.svh =====
// Assertion macros used by the RTL file icgs_back of the cluster scorer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Checked on every rising edge, ignored while reset is held.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
// Checked on every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ===== sv/icgs_pkg.sv =====
// ----------------------------------------------------------------------------
// icgs_pkg
// Types and constants shared by the isotropic Gaussian cluster scorer.
// ----------------------------------------------------------------------------
`default_nettype none
package icgs_pkg;

    localparam int DEF_MAX_DIM      = 16;
    localparam int DEF_NUM_CLUSTERS = 64;

    localparam int COORD_W  = 32;
    localparam int CID_W    = 6;
    localparam int TOT_W    = 48;
    localparam int CNT_W    = 16;
    localparam int ACC_W    = 64;
    localparam int SCORE_W  = 48;
    localparam int POS_W    = 6;
    localparam int VLEN_W   = 5;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 3;
    localparam int OUT_QW   = SCORE_W + 1;

    typedef enum logic [1:0] {
        MODE_ADD    = 2'd0,
        MODE_REMOVE = 2'd1,
        MODE_EXIST  = 2'd2,
        MODE_NEW    = 2'd3
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_VECTOR_LENGTH      = 3'd0,
        REG_OFFSET_EXISTING    = 3'd1,
        REG_HALF_INV_SCALE     = 3'd2,
        REG_OFFSET_NEW         = 3'd3,
        REG_HALF_INV_SCALE_ALL = 3'd4
    } t_reg_idx;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_DIV,
        S_CEN,
        S_SQ,
        S_ACC,
        S_PHI,
        S_PLO,
        S_PEN,
        S_SCORE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [VLEN_W-1:0]  vector_length;
        logic [CFG_W-1:0]   offset_existing;
        logic [CFG_W-1:0]   half_inv_scale;
        logic [CFG_W-1:0]   offset_new;
        logic [CFG_W-1:0]   half_inv_scale_all;
    } t_cfg;

    // One classified request as it waits between the front and the back.
    typedef struct packed {
        t_mode              mode;
        logic [CID_W-1:0]   cid;
        logic [COORD_W-1:0] coord;
        logic [POS_W-1:0]   pos;
        logic               first;
        logic               last;
        logic               valid;
    } t_item;

endpackage
`default_nettype wire

// ===== sv/icgs_fifo.sv =====
// ----------------------------------------------------------------------------
// icgs_fifo
// Small synchronous queue with registered entries.
// ----------------------------------------------------------------------------
`default_nettype none
module icgs_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire logic [W-1:0] i_din,
    input  wire logic         i_pop,
    output logic [W-1:0]      o_dout,
    output logic              o_full,
    output logic              o_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [W-1:0]  r_mem [DEPTH];
    logic [PW-1:0] r_wp, n_wp;
    logic [PW-1:0] r_rp, n_rp;
    logic [PW:0]   r_cnt, n_cnt;
    logic          do_push, do_pop;

    assign o_full  = (r_cnt == (PW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_dout  = r_mem[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wp = (r_wp == PW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
        end
        if (do_pop) begin
            n_rp = (r_rp == PW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_din;
        end
    end
endmodule
`default_nettype wire

// ===== sv/icgs_front.sv =====
// ----------------------------------------------------------------------------
// icgs_front
// Accepts coordinate requests, tags each with its place in the point and
// queues it for the back end.
// ----------------------------------------------------------------------------
`default_nettype none
module icgs_front #(
    parameter int MAX_DIM      = icgs_pkg::DEF_MAX_DIM,
    parameter int NUM_CLUSTERS = icgs_pkg::DEF_NUM_CLUSTERS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire icgs_pkg::t_cfg                i_cfg,
    input  wire logic                          i_clearing,
    input  wire logic                          i_push,
    output logic                               o_full,
    input  wire logic [1:0]                    i_mode,
    input  wire logic [icgs_pkg::CID_W-1:0]    i_component_id,
    input  wire logic [icgs_pkg::COORD_W-1:0]  i_coordinate,
    input  wire logic                          i_pop,
    output icgs_pkg::t_item                    o_item,
    output logic                               o_empty
);
    logic [icgs_pkg::POS_W-1:0] r_pos, n_pos;
    logic [7:0]                 len_eff;
    logic                       accept, q_full;
    icgs_pkg::t_item            item;

    // A length of zero behaves as one, anything above MAX_DIM as MAX_DIM.
    always_comb begin
        if (i_cfg.vector_length == '0) begin
            len_eff = 8'd1;
        end else if (32'(i_cfg.vector_length) > MAX_DIM) begin
            len_eff = 8'(MAX_DIM);
        end else begin
            len_eff = 8'(i_cfg.vector_length);
        end
    end

    assign o_full = q_full || i_clearing;
    assign accept = i_push && !o_full;

    always_comb begin
        item.mode  = icgs_pkg::t_mode'(i_mode);
        item.cid   = i_component_id;
        item.coord = i_coordinate;
        item.pos   = r_pos;
        item.first = (r_pos == '0);
        item.last  = ((8'(r_pos) + 8'd1) >= len_eff);
        item.valid = (32'(i_component_id) < NUM_CLUSTERS);
        n_pos      = r_pos;
        if (accept) begin
            n_pos = item.last ? '0 : r_pos + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else begin
            r_pos <= n_pos;
        end
    end

    icgs_fifo #(
        .W     ($bits(icgs_pkg::t_item)),
        .DEPTH (4)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_din   (item),
        .i_pop   (i_pop),
        .o_dout  (o_item),
        .o_full  (q_full),
        .o_empty (o_empty)
    );
endmodule
`default_nettype wire

// ===== sv/icgs_back.sv =====
// ----------------------------------------------------------------------------
// icgs_back
// Sequencer that carries out one queued request at a time: sum memory
// update, mean division, squared distance and final score.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module icgs_back #(
    parameter int MAX_DIM      = icgs_pkg::DEF_MAX_DIM,
    parameter int NUM_CLUSTERS = icgs_pkg::DEF_NUM_CLUSTERS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire icgs_pkg::t_cfg                i_cfg,
    output logic                               o_clearing,
    input  wire icgs_pkg::t_item               i_item,
    input  wire logic                          i_q_empty,
    output logic                               o_q_pop,
    input  wire logic                          i_out_full,
    output logic                               o_out_push,
    output logic [icgs_pkg::OUT_QW-1:0]        o_out_data
);
    localparam int DEPTH = NUM_CLUSTERS * MAX_DIM;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = (NUM_CLUSTERS > 1) ? $clog2(NUM_CLUSTERS) : 1;
    localparam int TW    = icgs_pkg::TOT_W;
    localparam int NW    = icgs_pkg::CNT_W;
    localparam int XW    = icgs_pkg::COORD_W;
    localparam int AccW  = icgs_pkg::ACC_W;
    localparam int SW    = icgs_pkg::SCORE_W;

    icgs_pkg::t_state r_state, n_state;
    icgs_pkg::t_item  r_item;

    logic [TW-1:0]   r_tot_mem [DEPTH];
    logic [NW-1:0]   r_cnt_mem [NUM_CLUSTERS];
    logic [TW-1:0]   r_tot_rd;
    logic [NW-1:0]   r_cnt_rd;
    logic [AW-1:0]   r_clr;

    logic [TW-1:0]   r_quo;
    logic [NW-1:0]   r_rem;
    logic [5:0]      r_bits;
    logic            r_neg;
    logic [XW-1:0]   r_cen;
    logic [63:0]     r_prod;
    logic [63:0]     r_hi;
    logic [AccW-1:0] r_acc;
    logic [TW:0]     r_pen;
    logic [SW-1:0]   r_score;
    logic            r_empty;

    logic            tot_we, tot_re, cnt_we, cnt_re;
    logic [AW-1:0]   tot_wa, tot_ra, item_addr;
    logic [TW-1:0]   tot_wd;
    logic [CW-1:0]   cnt_wa, cnt_ra;
    logic [NW-1:0]   cnt_wd;
    logic [31:0]     mult_a, mult_b;
    logic            is_empty, need_out;
    logic [NW:0]     trial;
    logic            trial_ge;
    logic [TW:0]     mean;
    logic [TW+1:0]   diff;
    logic [XW-1:0]   cen_sat, cen_abs;
    logic [AccW:0]   acc_sum;
    logic [63:0]     pen_sum;
    logic [TW:0]     pen_val;
    logic [XW-1:0]   off_sel, scale_sel;
    logic [TW+1:0]   score_raw;
    logic [SW-1:0]   score_sat;
    logic [TW-1:0]   tot_mag;

    assign o_clearing = (r_state == icgs_pkg::S_CLEAR);
    assign item_addr  = AW'(32'(r_item.cid) * MAX_DIM + 32'(r_item.pos));
    assign is_empty   = !r_item.valid || (r_cnt_rd == '0);
    assign need_out   = r_item.last && (r_item.mode == icgs_pkg::MODE_EXIST ||
                                        r_item.mode == icgs_pkg::MODE_NEW);
    assign o_out_data = {r_score, r_empty};

    // Restoring division step, one quotient bit a cycle.
    assign trial    = {r_rem, r_quo[TW-1]};
    assign trial_ge = (trial >= {1'b0, r_cnt_rd});
    assign tot_mag  = r_tot_rd[TW-1] ? TW'(-r_tot_rd) : r_tot_rd;

    always_comb begin
        mean    = r_neg ? (TW+1)'(-{1'b0, r_quo}) : {1'b0, r_quo};
        diff    = {{(TW+2-XW){r_item.coord[XW-1]}}, r_item.coord}
                - {mean[TW], mean};
        if (diff[TW+1:XW-1] == '0 || diff[TW+1:XW-1] == '1) begin
            cen_sat = diff[XW-1:0];
        end else if (diff[TW+1]) begin
            cen_sat = {1'b1, {(XW-1){1'b0}}};
        end else begin
            cen_sat = {1'b0, {(XW-1){1'b1}}};
        end
        cen_abs = r_cen[XW-1] ? XW'(-r_cen) : r_cen;
        acc_sum = {1'b0, r_acc} + (AccW+1)'(r_prod[63:16]);
        pen_sum = {r_hi[46:0], 16'b0} + 64'(r_prod[63:16]);
        if (r_hi[63:47] != '0 || pen_sum > 64'(1) << TW) begin
            pen_val = {1'b1, {TW{1'b0}}};
        end else begin
            pen_val = pen_sum[TW:0];
        end
        if (r_item.mode == icgs_pkg::MODE_EXIST) begin
            off_sel   = i_cfg.offset_existing;
            scale_sel = i_cfg.half_inv_scale;
        end else begin
            off_sel   = i_cfg.offset_new;
            scale_sel = i_cfg.half_inv_scale_all;
        end
        score_raw = {{(TW+2-XW){off_sel[XW-1]}}, off_sel} - {1'b0, r_pen};
        if (score_raw[TW+1:SW-1] == '0 || score_raw[TW+1:SW-1] == '1) begin
            score_sat = score_raw[SW-1:0];
        end else if (score_raw[TW+1]) begin
            score_sat = {1'b1, {(SW-1){1'b0}}};
        end else begin
            score_sat = {1'b0, {(SW-1){1'b1}}};
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            icgs_pkg::S_CLEAR: begin
                if (r_clr == AW'(DEPTH-1)) n_state = icgs_pkg::S_IDLE;
            end
            icgs_pkg::S_IDLE: begin
                if (!i_q_empty) n_state = icgs_pkg::S_READ;
            end
            icgs_pkg::S_READ: begin
                case (r_item.mode)
                    icgs_pkg::MODE_EXIST: begin
                        n_state = is_empty ? icgs_pkg::S_DONE : icgs_pkg::S_DIV;
                    end
                    icgs_pkg::MODE_NEW: n_state = icgs_pkg::S_SQ;
                    default:            n_state = icgs_pkg::S_DONE;
                endcase
            end
            icgs_pkg::S_DIV: begin
                if (r_bits == 6'd1) n_state = icgs_pkg::S_CEN;
            end
            icgs_pkg::S_CEN:   n_state = icgs_pkg::S_SQ;
            icgs_pkg::S_SQ:    n_state = icgs_pkg::S_ACC;
            icgs_pkg::S_ACC: begin
                n_state = r_item.last ? icgs_pkg::S_PHI : icgs_pkg::S_DONE;
            end
            icgs_pkg::S_PHI:   n_state = icgs_pkg::S_PLO;
            icgs_pkg::S_PLO:   n_state = icgs_pkg::S_PEN;
            icgs_pkg::S_PEN:   n_state = icgs_pkg::S_SCORE;
            icgs_pkg::S_SCORE: n_state = icgs_pkg::S_DONE;
            icgs_pkg::S_DONE: begin
                if (!(need_out && i_out_full)) n_state = icgs_pkg::S_IDLE;
            end
            default: n_state = icgs_pkg::S_IDLE;
        endcase
    end

    // Control outputs and memory ports.
    always_comb begin
        o_q_pop    = 1'b0;
        o_out_push = 1'b0;
        tot_we     = 1'b0;
        tot_wa     = item_addr;
        tot_wd     = r_tot_rd;
        tot_re     = 1'b0;
        tot_ra     = AW'(32'(i_item.cid) * MAX_DIM + 32'(i_item.pos));
        cnt_we     = 1'b0;
        cnt_wa     = CW'(r_item.cid);
        cnt_wd     = r_cnt_rd;
        cnt_re     = 1'b0;
        cnt_ra     = CW'(i_item.cid);
        mult_a     = cen_abs;
        mult_b     = cen_abs;
        case (r_state)
            icgs_pkg::S_CLEAR: begin
                tot_we = 1'b1;
                tot_wa = r_clr;
                tot_wd = '0;
                cnt_we = (32'(r_clr) < NUM_CLUSTERS);
                cnt_wa = CW'(r_clr);
                cnt_wd = '0;
            end
            icgs_pkg::S_IDLE: begin
                o_q_pop = !i_q_empty;
                tot_re  = !i_q_empty;
                cnt_re  = !i_q_empty;
            end
            icgs_pkg::S_READ: begin
                if (r_item.valid && r_item.mode == icgs_pkg::MODE_ADD) begin
                    tot_we = 1'b1;
                    tot_wd = r_tot_rd + {{(TW-XW){r_item.coord[XW-1]}}, r_item.coord};
                end else if (r_item.valid && r_item.mode == icgs_pkg::MODE_REMOVE) begin
                    tot_we = 1'b1;
                    tot_wd = r_tot_rd - {{(TW-XW){r_item.coord[XW-1]}}, r_item.coord};
                end
            end
            icgs_pkg::S_PHI: begin
                mult_a = r_acc[63:32];
                mult_b = scale_sel;
            end
            icgs_pkg::S_PLO: begin
                mult_a = r_acc[31:0];
                mult_b = scale_sel;
            end
            icgs_pkg::S_DONE: begin
                o_out_push = need_out && !i_out_full;
                if (r_item.last && r_item.valid) begin
                    if (r_item.mode == icgs_pkg::MODE_ADD) begin
                        cnt_we = 1'b1;
                        cnt_wd = (r_cnt_rd == '1) ? r_cnt_rd : r_cnt_rd + 1'b1;
                    end else if (r_item.mode == icgs_pkg::MODE_REMOVE) begin
                        cnt_we = 1'b1;
                        cnt_wd = (r_cnt_rd == '0) ? r_cnt_rd : r_cnt_rd - 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (tot_we) r_tot_mem[tot_wa] <= tot_wd;
        if (tot_re) r_tot_rd <= r_tot_mem[tot_ra];
    end

    always_ff @(posedge i_clk) begin
        if (cnt_we) r_cnt_mem[cnt_wa] <= cnt_wd;
        if (cnt_re) r_cnt_rd <= r_cnt_mem[cnt_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= icgs_pkg::S_CLEAR;
            r_clr   <= '0;
            r_acc   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == icgs_pkg::S_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (r_state == icgs_pkg::S_READ && r_item.first) begin
                r_acc <= '0;
            end else if (r_state == icgs_pkg::S_ACC) begin
                r_acc <= acc_sum[AccW] ? '1 : acc_sum[AccW-1:0];
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_prod <= 64'(mult_a) * 64'(mult_b);
        case (r_state)
            icgs_pkg::S_IDLE: begin
                if (!i_q_empty) r_item <= i_item;
            end
            icgs_pkg::S_READ: begin
                r_empty <= 1'b0;
                r_score <= '0;
                r_cen   <= r_item.coord;
                r_neg   <= r_tot_rd[TW-1];
                r_quo   <= tot_mag;
                r_rem   <= '0;
                r_bits  <= 6'(TW);
                if (r_item.mode == icgs_pkg::MODE_EXIST && is_empty) begin
                    r_empty <= 1'b1;
                end
            end
            icgs_pkg::S_DIV: begin
                r_rem  <= trial_ge ? NW'(trial - {1'b0, r_cnt_rd}) : NW'(trial);
                r_quo  <= {r_quo[TW-2:0], trial_ge};
                r_bits <= r_bits - 1'b1;
            end
            icgs_pkg::S_CEN:   r_cen   <= cen_sat;
            icgs_pkg::S_PLO:   r_hi    <= r_prod;
            icgs_pkg::S_PEN:   r_pen   <= pen_val;
            icgs_pkg::S_SCORE: r_score <= score_sat;
            default: begin
            end
        endcase
    end

    `ASSERT_CLK(a_no_pop_in_clear, i_clk, i_rst_n,
        (r_state == icgs_pkg::S_CLEAR) |-> !o_q_pop)
    `ASSERT_CLK(a_push_only_with_room, i_clk, i_rst_n,
        o_out_push |-> (!i_out_full && r_state == icgs_pkg::S_DONE))
    `ASSERT_CLK(a_divider_runs, i_clk, i_rst_n,
        (r_state == icgs_pkg::S_DIV && r_bits > 6'd1) |=> (r_state == icgs_pkg::S_DIV))
    `ASSERT_ALWAYS(a_reset_clears, i_clk,
        !i_rst_n |=> (r_state == icgs_pkg::S_CLEAR && r_clr == '0))
endmodule
`default_nettype wire

// ===== sv/isotropic_gaussian_cluster_scorer.sv =====
// Per coordinate: add or remove runs IDLE, READ and DONE; score new cluster adds
// SQ and ACC; score existing adds the bit-serial mean divider (DIV), CEN, SQ and
// ACC; empty cluster runs IDLE, READ and DONE; the last coordinate of a score adds
// PHI, PLO, PEN and SCORE. DONE waits while a score is due and the result queue is
// full; a 4-entry queue buffers requests. Reset is synchronous, active low; after
// it a clearing pass holds full high while the sums and counts are zeroed.
// ----------------------------------------------------------------------------
// isotropic_gaussian_cluster_scorer
// Per-cluster coordinate sums and counts with isotropic Gaussian scoring.
// ----------------------------------------------------------------------------
`default_nettype none
module isotropic_gaussian_cluster_scorer #(
    parameter int MAX_DIM      = icgs_pkg::DEF_MAX_DIM,
    parameter int NUM_CLUSTERS = icgs_pkg::DEF_NUM_CLUSTERS
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [icgs_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [icgs_pkg::CFG_W-1:0]         i_cfg_wdata,
    input  wire logic                               push,
    output logic                                    full,
    input  wire logic [1:0]                         i_mode,
    input  wire logic [icgs_pkg::CID_W-1:0]         i_component_id,
    input  wire logic [icgs_pkg::COORD_W-1:0]       i_coordinate,
    output logic                                    empty,
    input  wire logic                               pop,
    output logic [icgs_pkg::SCORE_W-1:0]            o_score,
    output logic                                    o_empty_component
);
    icgs_pkg::t_cfg                 r_cfg;
    icgs_pkg::t_item                q_item;
    logic                           q_empty, q_pop, clearing;
    logic                           out_full, out_push;
    logic [icgs_pkg::OUT_QW-1:0]    out_din, out_dout;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.vector_length      <= 5'd16;
            r_cfg.offset_existing    <= '0;
            r_cfg.half_inv_scale     <= 32'd32768;
            r_cfg.offset_new         <= '0;
            r_cfg.half_inv_scale_all <= 32'd32768;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                icgs_pkg::REG_VECTOR_LENGTH:
                    r_cfg.vector_length <= i_cfg_wdata[icgs_pkg::VLEN_W-1:0];
                icgs_pkg::REG_OFFSET_EXISTING:    r_cfg.offset_existing    <= i_cfg_wdata;
                icgs_pkg::REG_HALF_INV_SCALE:     r_cfg.half_inv_scale     <= i_cfg_wdata;
                icgs_pkg::REG_OFFSET_NEW:         r_cfg.offset_new         <= i_cfg_wdata;
                icgs_pkg::REG_HALF_INV_SCALE_ALL: r_cfg.half_inv_scale_all <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    icgs_front #(
        .MAX_DIM      (MAX_DIM),
        .NUM_CLUSTERS (NUM_CLUSTERS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_clearing     (clearing),
        .i_push         (push),
        .o_full         (full),
        .i_mode         (i_mode),
        .i_component_id (i_component_id),
        .i_coordinate   (i_coordinate),
        .i_pop          (q_pop),
        .o_item         (q_item),
        .o_empty        (q_empty)
    );

    icgs_back #(
        .MAX_DIM      (MAX_DIM),
        .NUM_CLUSTERS (NUM_CLUSTERS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .o_clearing (clearing),
        .i_item     (q_item),
        .i_q_empty  (q_empty),
        .o_q_pop    (q_pop),
        .i_out_full (out_full),
        .o_out_push (out_push),
        .o_out_data (out_din)
    );

    icgs_fifo #(
        .W     (icgs_pkg::OUT_QW),
        .DEPTH (2)
    ) u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_din   (out_din),
        .i_pop   (pop),
        .o_dout  (out_dout),
        .o_full  (out_full),
        .o_empty (empty)
    );

    assign o_score           = out_dout[icgs_pkg::OUT_QW-1:1];
    assign o_empty_component = out_dout[0];
endmodule
`default_nettype wire

// ===== bench/isotropic_gaussian_cluster_scorer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isotropic_gaussian_cluster_scorer_tb
// Drives add, remove and score requests into the cluster scorer through its
// queue-style ports under several idling patterns and register settings. A
// scoreboard keeps its own copy of the cluster sums and counts, predicts each
// score and compares it with what the block returns.
// ----------------------------------------------------------------------------
`default_nettype none
module isotropic_gaussian_cluster_scorer_tb;
    import icgs_pkg::*;

    localparam int NDIM = 16;
    localparam int NCL  = 64;
    localparam int WATCHDOG_LIMIT = 200000;

    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic               empty_comp;
    } t_score_result;

    class cluster_scoreboard;
        logic [TOT_W-1:0]   sums [NCL*NDIM];
        logic [CNT_W-1:0]   counts [NCL];
        int unsigned        pos;
        logic [ACC_W-1:0]   dist_acc;
        logic [VLEN_W-1:0]  vlen;
        logic [31:0]        off_exist, scale_exist, off_new, scale_new;
        t_score_result      pending [$];
        int                 errors;

        function new();
            foreach (sums[i]) sums[i] = '0;
            foreach (counts[i]) counts[i] = '0;
            pos = 0; dist_acc = '0; errors = 0;
            vlen = 16; off_exist = 0; scale_exist = 32768;
            off_new = 0; scale_new = 32768;
        endfunction

        function void write_reg(t_reg_idx idx, logic [31:0] v);
            case (idx)
                REG_VECTOR_LENGTH:      vlen = v[VLEN_W-1:0];
                REG_OFFSET_EXISTING:    off_exist = v;
                REG_HALF_INV_SCALE:     scale_exist = v;
                REG_OFFSET_NEW:         off_new = v;
                REG_HALF_INV_SCALE_ALL: scale_new = v;
                default: ;
            endcase
        endfunction

        function logic [63:0] square_q16(logic signed [63:0] c);
            logic [63:0] a;
            if (c > 64'sd2147483647) c = 64'sd2147483647;
            if (c < -64'sd2147483648) c = -64'sd2147483648;
            a = (c < 0) ? -c : c;
            return (a * a) >> 16;
        endfunction

        function logic [SCORE_W-1:0] log_likelihood(logic [31:0] off, logic [31:0] scale);
            logic [127:0] prod;
            logic [63:0]  pen;
            logic signed [63:0] s;
            // The full product shifted down matches the split multiply, then capped.
            prod = ({64'd0, dist_acc} * {96'd0, scale}) >> 16;
            pen = (prod > 128'h1_0000_0000_0000) ? 64'h1_0000_0000_0000 : prod[63:0];
            s = $signed({{32{off[31]}}, off}) - $signed(pen);
            if (s > 64'sh7FFF_FFFF_FFFF) s = 64'sh7FFF_FFFF_FFFF;
            if (s < -64'sh8000_0000_0000) s = -64'sh8000_0000_0000;
            return s[SCORE_W-1:0];
        endfunction

        function void note_request(t_mode mode, logic [5:0] cid, logic [31:0] x);
            int unsigned len, p, idx;
            logic [CNT_W-1:0] cnt;
            logic [63:0] term, s;
            logic signed [63:0] tot, mean;
            bit last;
            len = (vlen < 1) ? 1 : (vlen > NDIM ? NDIM : vlen);
            p = pos;
            cnt = counts[cid];
            idx = cid * NDIM + p;
            last = (p + 1 >= len);
            term = 0;
            if (p == 0) dist_acc = 0;
            case (mode)
                MODE_ADD:    sums[idx] = sums[idx] + {{16{x[31]}}, x};
                MODE_REMOVE: sums[idx] = sums[idx] - {{16{x[31]}}, x};
                MODE_EXIST: if (cnt != 0) begin
                    tot = $signed({{16{sums[idx][47]}}, sums[idx]});
                    mean = tot / $signed({48'd0, cnt});
                    term = square_q16($signed({{32{x[31]}}, x}) - mean);
                end
                default: term = square_q16($signed({{32{x[31]}}, x}));
            endcase
            s = dist_acc + term;
            dist_acc = (s < term) ? '1 : s;
            pos = last ? 0 : p + 1;
            if (!last) return;
            case (mode)
                MODE_ADD:    if (counts[cid] != 16'hFFFF) counts[cid]++;
                MODE_REMOVE: if (counts[cid] != 0) counts[cid]--;
                MODE_EXIST:
                    if (cnt == 0) pending.push_back('{score: '0, empty_comp: 1'b1});
                    else pending.push_back('{score: log_likelihood(off_exist, scale_exist),
                                             empty_comp: 1'b0});
                default: pending.push_back('{score: log_likelihood(off_new, scale_new),
                                             empty_comp: 1'b0});
            endcase
        endfunction

        function void check_result(logic [SCORE_W-1:0] score, logic empty_comp);
            t_score_result e;
            if (pending.size() == 0) begin
                $error("score result with no request waiting: score %h", score);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (score !== e.score) begin
                $error("score: expected %h actual %h", e.score, score);
                errors++;
            end
            if (empty_comp !== e.empty_comp) begin
                $error("empty_component: expected %b actual %b", e.empty_comp, empty_comp);
                errors++;
            end
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_wdata = '0;
    logic                 push = 1'b0;
    logic                 full;
    logic [1:0]           i_mode = '0;
    logic [CID_W-1:0]     i_component_id = '0;
    logic [COORD_W-1:0]   i_coordinate = '0;
    logic                 empty;
    logic                 pop = 1'b0;
    logic [SCORE_W-1:0]   o_score;
    logic                 o_empty_component;

    cluster_scoreboard sb = new();
    int  send_idle_pct = 0;
    int  stall_pct = 0;
    int  idle_cycles = 0;

    always #5 i_clk = ~i_clk;

    isotropic_gaussian_cluster_scorer dut (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_wdata,
        .push, .full, .i_mode, .i_component_id, .i_coordinate,
        .empty, .pop, .o_score, .o_empty_component
    );

    // Results side: random stalls, checks every accepted result.
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) sb.check_result(o_score, o_empty_component);
        pop <= ($urandom_range(99) >= stall_pct);
    end

    // Watchdog on cycles without any accepted request or result.
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || !i_rst_n) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Push stays high after a request; the next request, an idle cycle or a
    // drain takes it down, so it is assigned only once per clock edge.
    task automatic send_request(t_mode mode, logic [5:0] cid, logic [31:0] x);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push <= 1'b1;
        i_mode <= mode;
        i_component_id <= cid;
        i_coordinate <= x;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        sb.note_request(mode, cid, x);
    endtask

    task automatic send_point(t_mode mode, logic [5:0] cid, int kind);
        int unsigned len;
        logic [31:0] x;
        len = (sb.vlen < 1) ? 1 : (sb.vlen > NDIM ? NDIM : sb.vlen);
        for (int d = 0; d < len; d++) begin
            case (kind)
                0: x = $urandom_range(32'h0004_0000) - 32'h0002_0000;
                1: x = $urandom();
                2: x = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
                default: x = $urandom_range(32'h00FF_FFFF) - 32'h0080_0000;
            endcase
            send_request(mode, cid, x);
        end
    endtask

    task automatic drain();
        push <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        // A trailing add or remove may still be in flight.
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg_idx idx, logic [31:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        sb.write_reg(idx, v);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic random_phase(int n);
        int r;
        t_mode m;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            m = (r < 35) ? MODE_ADD : (r < 45) ? MODE_REMOVE : (r < 85) ? MODE_EXIST
                : MODE_NEW;
            send_point(m, $urandom_range(r < 60 ? 7 : 63), $urandom_range(3));
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: short points, extremes, empty cluster, mixed modes.
        write_reg(REG_VECTOR_LENGTH, 2);
        send_point(MODE_EXIST, 5, 0);
        send_point(MODE_NEW, 0, 2);
        send_request(MODE_NEW, 63, 32'h8000_0000);
        send_request(MODE_NEW, 63, 32'h8000_0000);
        send_point(MODE_ADD, 63, 2);
        send_point(MODE_ADD, 63, 1);
        send_point(MODE_EXIST, 63, 2);
        send_request(MODE_ADD, 1, 32'h7FFF_FFFF);
        send_request(MODE_EXIST, 63, 32'h0);
        send_point(MODE_REMOVE, 63, 0);
        send_point(MODE_REMOVE, 63, 0);
        send_point(MODE_REMOVE, 63, 0);
        send_point(MODE_EXIST, 63, 0);
        drain();
        write_reg(REG_VECTOR_LENGTH, 0);
        write_reg(REG_HALF_INV_SCALE_ALL, 32'hFFFF_FFFF);
        write_reg(REG_OFFSET_NEW, 32'h7FFF_FFFF);
        send_point(MODE_NEW, 3, 2);
        send_point(MODE_NEW, 3, 0);
        drain();

        // Random phases over several settings and idling patterns.
        for (int ph = 0; ph < 8; ph++) begin
            send_idle_pct = (ph % 4 == 1 || ph % 4 == 3) ? 45 : 0;
            stall_pct = (ph % 4 == 2) ? 45 : (ph % 4 == 3) ? 15 : 0;
            if (ph % 4 == 3) send_idle_pct = 15;
            write_reg(REG_VECTOR_LENGTH, (ph == 0) ? 1 : (ph == 7) ? 31 : $urandom_range(16));
            write_reg(REG_OFFSET_EXISTING, (ph == 2) ? 32'h8000_0000 : $urandom());
            write_reg(REG_HALF_INV_SCALE, (ph == 3) ? 32'hFFFF_FFFF : (ph == 4) ? 0
                      : $urandom_range(32'h0002_0000));
            write_reg(REG_OFFSET_NEW, $urandom());
            write_reg(REG_HALF_INV_SCALE_ALL, (ph == 5) ? 0 : $urandom_range(32'h0002_0000));
            write_reg(t_reg_idx'(3'd7), $urandom());
            random_phase(ph == 0 ? 150 : 26);
            drain();
        end

        drain();
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ===== isotropic_gaussian_cluster_scorer.f =====
+incdir+sv
sv/icgs_pkg.sv
sv/icgs_fifo.sv
sv/icgs_front.sv
sv/icgs_back.sv
sv/isotropic_gaussian_cluster_scorer.sv
bench/isotropic_gaussian_cluster_scorer_tb.sv
